### rtl/pfse_pkg.sv
package pfse_pkg;

   localparam int Size = 5;
   localparam int CodeWidth = 5;
   localparam int PosWidth = 3;
   localparam int RowWidth = Size * CodeWidth;
   localparam int CharWidth = 8;
   localparam int AsciiWidth = 7;
   localparam int CsrIndexWidth = 3;
   localparam int FifoDepth = 4;
   localparam int FifoPtrWidth = 2;
   localparam int FifoCountWidth = 3;

   localparam logic [CsrIndexWidth-1:0] RegSquareRowCount = CsrIndexWidth'(Size);

   localparam logic [CodeWidth-1:0] CodeI = 5'd8;
   localparam logic [CodeWidth-1:0] CodeJ = 5'd9;
   localparam logic [CodeWidth-1:0] CodeX = 5'd23;
   localparam logic [AsciiWidth-1:0] AsciiA = 7'd65;
   localparam logic [CharWidth-1:0] UpperA = 8'd65;
   localparam logic [CharWidth-1:0] UpperZ = 8'd90;
   localparam logic [CharWidth-1:0] LowerA = 8'd97;
   localparam logic [CharWidth-1:0] LowerZ = 8'd122;

   typedef logic [Size-1:0][RowWidth-1:0] square_type;

   typedef struct packed {
      logic [CharWidth-1:0] in_char;
      logic                 message_end;
   } req_payload_type;

   typedef struct packed {
      logic [AsciiWidth-1:0] cipher_char;
      logic                  last_of_run;
      logic                  message_done;
   } rsp_payload_type;

   typedef struct packed {
      logic [CodeWidth-1:0] first;
      logic [CodeWidth-1:0] second;
      logic                 last_of_run;
      logic                 message_done;
   } digraph_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   typedef struct packed {
      logic [PosWidth-1:0] row;
      logic [PosWidth-1:0] col;
   } pos_type;

   function automatic logic [CodeWidth-1:0] square_cell(square_type sq, logic [PosWidth-1:0] r,
                                                        logic [PosWidth-1:0] c);
      logic [RowWidth-1:0] row_bits;
      row_bits = sq[r];
      return row_bits[c*CodeWidth +: CodeWidth];
   endfunction

   function automatic logic [PosWidth-1:0] inc_mod(logic [PosWidth-1:0] x);
      return (x == PosWidth'(Size - 1)) ? '0 : x + PosWidth'(1);
   endfunction

   // The first matching cell in row-major order wins; a missing letter sits at row 0, column 0.
   function automatic pos_type locate(square_type sq, logic [CodeWidth-1:0] code);
      pos_type p;
      logic    found;
      p = '0;
      found = 1'b0;
      for (int r = 0; r < Size; r++) begin
         for (int c = 0; c < Size; c++) begin
            if (!found && (sq[r][c*CodeWidth +: CodeWidth] == code)) begin
               found = 1'b1;
               p.row = PosWidth'(r);
               p.col = PosWidth'(c);
            end
         end
      end
      return p;
   endfunction

endpackage

### rtl/pfse_front.sv
module pfse_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  pfse_pkg::req_payload_type req_payload,
   input  pfse_pkg::fifo_status_type q_status,
   output logic                      q_push,
   output pfse_pkg::digraph_type     q_push_data
);
   import pfse_pkg::*;

   logic                 pending_valid_ff, pending_valid_in;
   logic [CodeWidth-1:0] pending_letter_ff, pending_letter_in;
   logic                 extra_valid_ff, extra_valid_in;
   digraph_type          extra_ff, extra_in;

   logic                 accept;
   logic                 is_upper, is_lower, is_letter;
   logic [CodeWidth-1:0] code;
   logic                 has0, has1;
   digraph_type          d0, d1;
   logic                 pv_next;
   logic [CodeWidth-1:0] pl_next;

   assign req_stall = extra_valid_ff || q_status.full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      is_upper  = (req_payload.in_char >= UpperA) && (req_payload.in_char <= UpperZ);
      is_lower  = (req_payload.in_char >= LowerA) && (req_payload.in_char <= LowerZ);
      is_letter = is_upper || is_lower;
      code = is_lower ? CodeWidth'(req_payload.in_char - LowerA)
                      : CodeWidth'(req_payload.in_char - UpperA);
      if (code == CodeJ) begin
         code = CodeI;
      end
      has0    = 1'b0;
      has1    = 1'b0;
      d0      = '0;
      d1      = '0;
      pv_next = pending_valid_ff;
      pl_next = pending_letter_ff;
      if (is_letter) begin
         if (!pending_valid_ff) begin
            pv_next = 1'b1;
            pl_next = code;
         end else if (pending_letter_ff == code) begin
            d0.first  = pending_letter_ff;
            d0.second = CodeX;
            has0      = 1'b1;
         end else begin
            d0.first  = pending_letter_ff;
            d0.second = code;
            has0      = 1'b1;
            pv_next   = 1'b0;
            pl_next   = '0;
         end
      end
      if (req_payload.message_end) begin
         if (pv_next) begin
            if (has0) begin
               d1.first  = pl_next;
               d1.second = CodeX;
               has1      = 1'b1;
            end else begin
               d0.first  = pl_next;
               d0.second = CodeX;
               has0      = 1'b1;
            end
         end
         pv_next = 1'b0;
         pl_next = '0;
      end
      if (has1) begin
         d1.last_of_run  = 1'b1;
         d1.message_done = req_payload.message_end;
      end else if (has0) begin
         d0.last_of_run  = 1'b1;
         d0.message_done = req_payload.message_end;
      end
   end

   always_comb begin
      q_push      = extra_valid_ff ? !q_status.full : (accept && has0);
      q_push_data = extra_valid_ff ? extra_ff : d0;
      pending_valid_in  = accept ? pv_next : pending_valid_ff;
      pending_letter_in = accept ? pl_next : pending_letter_ff;
      extra_valid_in = extra_valid_ff;
      extra_in       = extra_ff;
      if (extra_valid_ff && !q_status.full) begin
         extra_valid_in = 1'b0;
      end else if (accept && has1) begin
         extra_valid_in = 1'b1;
         extra_in       = d1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_valid_ff  <= 1'b0;
         pending_letter_ff <= '0;
         extra_valid_ff    <= 1'b0;
      end else begin
         pending_valid_ff  <= pending_valid_in;
         pending_letter_ff <= pending_letter_in;
         extra_valid_ff    <= extra_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      extra_ff <= extra_in;
   end

endmodule

### rtl/pfse_fifo.sv
module pfse_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  pfse_pkg::digraph_type     push_data,
   input  logic                      pop,
   output pfse_pkg::digraph_type     head,
   output pfse_pkg::fifo_status_type status
);
   import pfse_pkg::*;

   digraph_type               mem_ff [FifoDepth];
   logic [FifoPtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FifoPtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FifoCountWidth-1:0] count_ff, count_in;

   assign status.full  = (count_ff == FifoCountWidth'(FifoDepth));
   assign status.empty = (count_ff == '0);
   assign head         = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + FifoPtrWidth'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + FifoPtrWidth'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + FifoCountWidth'(1);
      end else if (pop && !push) begin
         count_in = count_ff - FifoCountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/pfse_back.sv
module pfse_back (
   input  logic                      clock,
   input  logic                      reset,
   input  pfse_pkg::square_type      square,
   input  pfse_pkg::fifo_status_type q_status,
   input  pfse_pkg::digraph_type     q_head,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output pfse_pkg::rsp_payload_type rsp_payload
);
   import pfse_pkg::*;

   logic                 pos_valid_ff, pos_valid_in;
   pos_type              pos1_ff, pos1_in, pos2_ff, pos2_in;
   logic                 pos_last_ff, pos_done_ff;

   logic                 pair_valid_ff, pair_valid_in;
   logic                 pair_sel_ff, pair_sel_in;
   logic [CodeWidth-1:0] first_ff, first_in, second_ff, second_in;
   logic                 last_ff, done_ff;

   logic                 pair_free, pos_move, pos_free;
   logic [CodeWidth-1:0] out_code;

   assign pair_free = !pair_valid_ff || (pair_sel_ff && !rsp_stall);
   assign pos_move  = pos_valid_ff && pair_free;
   assign pos_free  = !pos_valid_ff || pos_move;
   assign q_pop     = !q_status.empty && pos_free;

   assign pos1_in = locate(square, q_head.first);
   assign pos2_in = locate(square, q_head.second);

   always_comb begin
      if (pos1_ff.row == pos2_ff.row) begin
         first_in  = square_cell(square, pos1_ff.row, inc_mod(pos1_ff.col));
         second_in = square_cell(square, pos2_ff.row, inc_mod(pos2_ff.col));
      end else if (pos1_ff.col == pos2_ff.col) begin
         first_in  = square_cell(square, inc_mod(pos1_ff.row), pos1_ff.col);
         second_in = square_cell(square, inc_mod(pos2_ff.row), pos2_ff.col);
      end else begin
         first_in  = square_cell(square, pos1_ff.row, pos2_ff.col);
         second_in = square_cell(square, pos2_ff.row, pos1_ff.col);
      end
   end

   always_comb begin
      pos_valid_in  = q_pop ? 1'b1 : (pos_move ? 1'b0 : pos_valid_ff);
      pair_valid_in = pair_valid_ff;
      pair_sel_in   = pair_sel_ff;
      if (pos_move) begin
         pair_valid_in = 1'b1;
         pair_sel_in   = 1'b0;
      end else if (pair_valid_ff && !rsp_stall) begin
         if (pair_sel_ff) begin
            pair_valid_in = 1'b0;
         end else begin
            pair_sel_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_valid_ff  <= 1'b0;
         pair_valid_ff <= 1'b0;
         pair_sel_ff   <= 1'b0;
      end else begin
         pos_valid_ff  <= pos_valid_in;
         pair_valid_ff <= pair_valid_in;
         pair_sel_ff   <= pair_sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         pos1_ff     <= pos1_in;
         pos2_ff     <= pos2_in;
         pos_last_ff <= q_head.last_of_run;
         pos_done_ff <= q_head.message_done;
      end
      if (pos_move) begin
         first_ff  <= first_in;
         second_ff <= second_in;
         last_ff   <= pos_last_ff;
         done_ff   <= pos_done_ff;
      end
   end

   assign out_code                 = pair_sel_ff ? second_ff : first_ff;
   assign rsp_valid                = pair_valid_ff;
   assign rsp_payload.cipher_char  = AsciiA + {{(AsciiWidth-CodeWidth){1'b0}}, out_code};
   assign rsp_payload.last_of_run  = pair_sel_ff && last_ff;
   assign rsp_payload.message_done = pair_sel_ff && done_ff;

endmodule

### rtl/playfair_stream_encrypt_top.sv
// Playfair encryptor for a byte stream. Each accepted item is one raw byte; non-letters are
// dropped, letters are folded to upper case with J taken as I, paired into digraphs with X
// inserted between doubled letters and X padding a lone letter at message end, and every
// digraph gives two ciphertext letters from the 5x5 key square held in csr rows 0 to 4.
// The front accepts one byte per cycle while the digraph queue is not full and no second
// digraph of an earlier byte waits, and feeds a four-entry digraph queue. The back locates
// both letters of the queue head, registers their positions and then delivers the two
// result letters, first then second, from its output register, so that register sets the
// sustained rate. A completing byte's digraph passes the queue, the position registers
// and the output register before its first letter appears. The user must write rows
// only while the block is idle; the block itself does not enforce it.
module playfair_stream_encrypt_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  pfse_pkg::req_payload_type              req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output pfse_pkg::rsp_payload_type              rsp_payload,
   input  logic                                   csr_write_en,
   input  logic [pfse_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [pfse_pkg::RowWidth-1:0]          csr_write_data
);
   import pfse_pkg::*;

   square_type      square_ff, square_in;
   fifo_status_type q_status;
   logic            q_push, q_pop;
   digraph_type     q_push_data, q_head;

   always_comb begin
      square_in = square_ff;
      if (csr_write_en && (csr_index < RegSquareRowCount)) begin
         square_in[csr_index] = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         square_ff <= '0;
      end else begin
         square_ff <= square_in;
      end
   end

   pfse_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   pfse_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .head      (q_head),
      .status    (q_status)
   );

   pfse_back u_back (
      .clock       (clock),
      .reset       (reset),
      .square      (square_ff),
      .q_status    (q_status),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("digraph queue written while full");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("digraph queue read while empty");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.message_done) |-> rsp_payload.last_of_run)
      else $error("message end letter not marked as last of its run");

   a_pair_second_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_payload.last_of_run && !rsp_payload.message_done
       && $past(rsp_valid) && !$past(rsp_stall) && $past(rsp_payload.last_of_run))
      |=> rsp_valid)
      else $error("second letter of a digraph missing");
`endif

endmodule

### test/tb_playfair_stream_encrypt_top.sv
module tb_playfair_stream_encrypt_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pfse_pkg::*;

   localparam int HoldOffCycles = 200;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   req_payload_type          req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   rsp_payload_type          rsp_payload;
   logic                     csr_write_en = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [RowWidth-1:0]      csr_write_data = '0;

   playfair_stream_encrypt_top DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // Key square as the block should hold it, plus the digraph state.
   logic [RowWidth-1:0]  key_rows [Size];
   logic [RowWidth-1:0]  staged_rows [Size];
   logic                 pend_valid = 1'b0;
   logic [CodeWidth-1:0] pend_code = '0;

   req_payload_type pending_bytes [$];
   rsp_payload_type cipher_expected [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_off_asked = 0;
   int hold_off_seen = 0;
   int hold_off_left = 0;
   int mismatch_count = 0;
   int bytes_accepted = 0;
   int letters_checked = 0;
   int messages_closed = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [CodeWidth-1:0] square_at(int r, int c);
      return key_rows[r][c*CodeWidth +: CodeWidth];
   endfunction

   function automatic void find_cell(logic [CodeWidth-1:0] code, output int r_at,
                                     output int c_at);
      logic hit;
      hit = 1'b0;
      r_at = 0;
      c_at = 0;
      for (int r = 0; r < Size; r++) begin
         for (int c = 0; c < Size; c++) begin
            if (!hit && square_at(r, c) == code) begin
               hit = 1'b1;
               r_at = r;
               c_at = c;
            end
         end
      end
   endfunction

   function automatic logic [2*CodeWidth-1:0] encipher(logic [CodeWidth-1:0] a,
                                                       logic [CodeWidth-1:0] b);
      int r1, c1, r2, c2;
      find_cell(a, r1, c1);
      find_cell(b, r2, c2);
      if (r1 == r2) begin
         return {square_at(r1, (c1 + 1) % Size), square_at(r2, (c2 + 1) % Size)};
      end else if (c1 == c2) begin
         return {square_at((r1 + 1) % Size, c1), square_at((r2 + 1) % Size, c2)};
      end
      return {square_at(r1, c2), square_at(r2, c1)};
   endfunction

   function automatic void predict_byte(req_payload_type item);
      logic [CodeWidth-1:0]   codes [4];
      logic [2*CodeWidth-1:0] pr;
      logic                   is_letter;
      logic [CodeWidth-1:0]   code;
      rsp_payload_type        res;
      int                     n;
      n = 0;
      is_letter = 1'b0;
      code = '0;
      if (item.in_char >= UpperA && item.in_char <= UpperZ) begin
         is_letter = 1'b1;
         code = CodeWidth'(item.in_char - UpperA);
      end else if (item.in_char >= LowerA && item.in_char <= LowerZ) begin
         is_letter = 1'b1;
         code = CodeWidth'(item.in_char - LowerA);
      end
      if (is_letter) begin
         if (code == CodeJ) code = CodeI;
         if (!pend_valid) begin
            pend_valid = 1'b1;
            pend_code = code;
         end else if (pend_code == code) begin
            pr = encipher(pend_code, CodeX);
            codes[0] = pr[2*CodeWidth-1:CodeWidth];
            codes[1] = pr[CodeWidth-1:0];
            n = 2;
         end else begin
            pr = encipher(pend_code, code);
            codes[0] = pr[2*CodeWidth-1:CodeWidth];
            codes[1] = pr[CodeWidth-1:0];
            n = 2;
            pend_valid = 1'b0;
            pend_code = '0;
         end
      end
      if (item.message_end) begin
         if (pend_valid) begin
            pr = encipher(pend_code, CodeX);
            codes[n] = pr[2*CodeWidth-1:CodeWidth];
            codes[n+1] = pr[CodeWidth-1:0];
            n = n + 2;
         end
         pend_valid = 1'b0;
         pend_code = '0;
      end
      for (int k = 0; k < n; k++) begin
         res.cipher_char = AsciiA + AsciiWidth'(codes[k]);
         res.last_of_run = (k == n - 1);
         res.message_done = item.message_end && (k == n - 1);
         cipher_expected.push_back(res);
      end
   endfunction

   task automatic flag_mismatch(string what);
      $display("[%0t] ERROR: %s", $realtime, what);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_byte(req_payload);
            bytes_accepted++;
            if (req_payload.message_end) messages_closed++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_payload <= pending_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_off_seen != hold_off_asked) begin
         hold_off_seen <= hold_off_asked;
         hold_off_left <= HoldOffCycles;
         rsp_stall <= 1'b1;
      end else if (hold_off_left > 0) begin
         hold_off_left <= hold_off_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_letters
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (cipher_expected.size() == 0) begin
            flag_mismatch($sformatf("letter %0d with nothing expected",
                                    rsp_payload.cipher_char));
         end else begin
            want = cipher_expected.pop_front();
            letters_checked++;
            if (rsp_payload.cipher_char !== want.cipher_char)
               flag_mismatch($sformatf("cipher_char %0d, expected %0d",
                                       rsp_payload.cipher_char, want.cipher_char));
            if (rsp_payload.last_of_run !== want.last_of_run)
               flag_mismatch($sformatf("last_of_run %b, expected %b",
                                       rsp_payload.last_of_run, want.last_of_run));
            if (rsp_payload.message_done !== want.message_done)
               flag_mismatch($sformatf("message_done %b, expected %b",
                                       rsp_payload.message_done, want.message_done));
         end
      end
   end

   task automatic push_byte(logic [CharWidth-1:0] ch, logic fin);
      req_payload_type item;
      item.in_char = ch;
      item.message_end = fin;
      pending_bytes.push_back(item);
   endtask

   task automatic push_text(string s, logic end_last);
      for (int k = 0; k < s.len(); k++) push_byte(s[k], end_last && (k == s.len() - 1));
   endtask

   task automatic write_csr(int idx, logic [RowWidth-1:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= CsrIndexWidth'(idx);
      csr_write_data <= value;
      if (idx < Size) key_rows[idx] = value;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic commit_square();
      foreach (staged_rows[r]) write_csr(r, staged_rows[r]);
   endtask

   task automatic stage_permutation(int corrupt);
      logic [CodeWidth-1:0] codes [Size*Size];
      logic [CodeWidth-1:0] t;
      int                   n, j;
      n = 0;
      for (int c = 0; c < 26; c++) begin
         if (c != CodeJ) begin
            codes[n] = CodeWidth'(c);
            n++;
         end
      end
      for (int i = Size*Size - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = codes[i];
         codes[i] = codes[j];
         codes[j] = t;
      end
      repeat (corrupt) codes[$urandom_range(0, Size*Size - 1)] = CodeWidth'($urandom_range(0, 31));
      for (int k = 0; k < Size*Size; k++)
         staged_rows[k/Size][(k%Size)*CodeWidth +: CodeWidth] = codes[k];
   endtask

   task automatic set_idling(int sender, int receiver);
      @(negedge clock);
      send_idle_pct = sender;
      recv_idle_pct = receiver;
   endtask

   task automatic drain(int settle);
      @(negedge clock);
      while (pending_bytes.size() != 0 || req_valid || cipher_expected.size() != 0)
         @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   // Mostly well-formed messages with doubled letters, J and X, some stray bytes.
   task automatic queue_messages(int letters_wanted);
      int                   queued, len, closing;
      logic [CodeWidth-1:0] code;
      logic [CharWidth-1:0] ch;
      queued = 0;
      code = '0;
      @(negedge clock);
      while (queued < letters_wanted) begin
         if ($urandom_range(0, 9) < 2) begin
            push_byte(CharWidth'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
         end else begin
            len = $urandom_range(1, 10);
            closing = $urandom_range(0, 9);
            for (int k = 0; k < len; k++) begin
               if (k == 0 || $urandom_range(0, 3) != 0) begin
                  if ($urandom_range(0, 9) == 0)
                     code = $urandom_range(0, 1) ? CodeJ : CodeX;
                  else
                     code = CodeWidth'($urandom_range(0, 25));
               end
               ch = CharWidth'(code) + ($urandom_range(0, 1) ? UpperA : LowerA);
               if ($urandom_range(0, 9) == 0)
                  push_byte(CharWidth'($urandom_range(0, 255)), 1'b0);
               push_byte(ch, (k == len - 1) && closing > 1);
            end
            if (closing == 1) push_byte(CharWidth'($urandom_range(0, 255)), 1'b1);
            queued += len;
         end
      end
   endtask

   initial begin
      string classic;
      classic = "PLAYFIREXMBCDGHKNOQSTUVWZ";
      foreach (key_rows[r]) key_rows[r] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      set_idling(32, 61);

      foreach (staged_rows[r]) staged_rows[r] = '0;
      commit_square();
      push_text("AbC", 1'b1);
      drain(10);

      for (int k = 0; k < Size*Size; k++)
         staged_rows[k/Size][(k%Size)*CodeWidth +: CodeWidth] = CodeWidth'(classic[k] - UpperA);
      commit_square();
      push_text("hiDEPFeeJXX", 1'b0);
      push_byte(8'h00, 1'b1);
      push_byte("@", 1'b1);
      push_byte("L", 1'b0);
      push_byte("l", 1'b1);
      push_byte(8'hFF, 1'b0);
      push_text("[`{Za", 1'b0);
      push_byte("z", 1'b1);
      drain(10);

      stage_permutation(0);
      commit_square();
      queue_messages(80);
      drain(10);

      foreach (staged_rows[r]) staged_rows[r] = '1;
      commit_square();
      queue_messages(20);
      drain(10);

      set_idling(61, 32);
      foreach (staged_rows[r]) staged_rows[r] = RowWidth'($urandom());
      commit_square();
      queue_messages(45);
      drain(10);

      write_csr($urandom_range(RegSquareRowCount, (1 << CsrIndexWidth) - 1),
                RowWidth'($urandom()));
      stage_permutation(3);
      commit_square();
      queue_messages(45);
      drain(10);

      set_idling(0, 0);
      stage_permutation(0);
      commit_square();
      queue_messages(25);
      hold_off_asked++;
      queue_messages(30);
      drain(0);
      queue_messages(25);
      drain(12);

      $display("Run covered %0d bytes in %0d closed messages over seven key squares.",
               bytes_accepted, messages_closed);
      $display("Checked %0d cipher letters under random stalls, a %0d-cycle hold-off and a pause.",
               letters_checked, HoldOffCycles);
      if (mismatch_count == 0) begin
         $display("playfair_stream_encrypt_top: match");
      end else begin
         $display("playfair_stream_encrypt_top: mismatch");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timed out with %0d letters still expected.", cipher_expected.size());
      $display("playfair_stream_encrypt_top: mismatch");
      $finish;
   end

endmodule
